// ----- design/txt_record_key_value_parse_core_assert.svh -----
// Assertion macros shared by the TXT record parser files.
`ifndef TXT_RECORD_KEY_VALUE_PARSE_CORE_ASSERT_SVH
`define TXT_RECORD_KEY_VALUE_PARSE_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TXTKV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TXTKV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/txtkv_pkg.sv -----
// ----------------------------------------------------------------------------
// txtkv_pkg: shared types and constants of the TXT record parser
// Input item and result item structures, command codes and separator char.
// ----------------------------------------------------------------------------
`default_nettype none

package txtkv_pkg;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Key/value separator character '='
  localparam logic [7:0] SEP_CHAR = 8'h3D;

  typedef struct packed {
    logic        cmd;
    logic [15:0] rdata_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_byte;
    logic       in_value;
    logic       entry_end;
    logic       record_end;
    logic       status;
  } result_t;

endpackage

`default_nettype wire

// ----- design/txtkv_parser.sv -----
// ----------------------------------------------------------------------------
// txtkv_parser: record parse state and per-item step logic
// Holds the byte and string counters and flags, and works out the result of
// one registered input item in combinational logic.
// ----------------------------------------------------------------------------
`default_nettype none

module txtkv_parser
  import txtkv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    item_valid,
  input  wire item_t   item,
  input  wire logic    advance,
  output logic         res_valid,
  output result_t      res
);

  `include "txt_record_key_value_parse_core_assert.svh"

  logic [15:0] bytes_rem_r, bytes_rem_nxt;
  logic [7:0]  str_rem_r, str_rem_nxt;
  logic        sep_seen_r, sep_seen_nxt;
  logic        active_r, active_nxt;

  logic [15:0] bytes_dec;
  logic [7:0]  str_dec;
  logic        rend;
  logic        eend;
  logic        emit;

  assign bytes_dec = bytes_rem_r - 16'd1;
  assign str_dec   = str_rem_r - 8'd1;
  assign rend      = (bytes_dec == 16'd0);
  assign eend      = (str_dec == 8'd0);

  // Step logic for one item
  always_comb begin
    bytes_rem_nxt = bytes_rem_r;
    str_rem_nxt   = str_rem_r;
    sep_seen_nxt  = sep_seen_r;
    active_nxt    = active_r;
    emit          = 1'b0;
    res           = '0;
    if (item.cmd == CMD_START) begin
      bytes_rem_nxt = item.rdata_length;
      str_rem_nxt   = 8'd0;
      sep_seen_nxt  = 1'b0;
      active_nxt    = (item.rdata_length != 16'd0);
      if (item.rdata_length == 16'd0) begin
        emit           = 1'b1;
        res.record_end = 1'b1;
      end
    end else if (active_r && (bytes_rem_r != 16'd0)) begin
      bytes_rem_nxt = bytes_dec;
      if (str_rem_r == 8'd0) begin
        // length byte
        if ({8'h00, item.data_byte} > bytes_dec) begin
          active_nxt     = 1'b0;
          bytes_rem_nxt  = 16'd0;
          emit           = 1'b1;
          res.record_end = 1'b1;
          res.status     = 1'b1;
        end else begin
          str_rem_nxt  = item.data_byte;
          sep_seen_nxt = 1'b0;
          if (rend) begin
            active_nxt     = 1'b0;
            emit           = 1'b1;
            res.record_end = 1'b1;
          end
        end
      end else begin
        // string content byte
        str_rem_nxt = str_dec;
        if (rend) begin
          active_nxt = 1'b0;
        end
        if ((item.data_byte == SEP_CHAR) && !sep_seen_r) begin
          sep_seen_nxt = 1'b1;
          if (eend) begin
            emit           = 1'b1;
            res.entry_end  = 1'b1;
            res.record_end = rend;
          end
        end else begin
          emit           = 1'b1;
          res.has_char   = 1'b1;
          res.char_byte  = item.data_byte;
          res.in_value   = sep_seen_r;
          res.entry_end  = eend;
          res.record_end = rend;
        end
      end
    end
  end

  assign res_valid = item_valid && emit;

  // State registers, updated as the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_rem_r <= 16'd0;
      str_rem_r   <= 8'd0;
      sep_seen_r  <= 1'b0;
      active_r    <= 1'b0;
    end else if (item_valid && advance) begin
      bytes_rem_r <= bytes_rem_nxt;
      str_rem_r   <= str_rem_nxt;
      sep_seen_r  <= sep_seen_nxt;
      active_r    <= active_nxt;
    end
  end

  // Checks
  `TXTKV_ASSERT(a_status_needs_end, (res_valid && res.status) |-> res.record_end, "status without record_end")
  `TXTKV_ASSERT(a_end_goes_idle, (res_valid && advance && res.record_end) |=> !active_r, "record_end left record active")
  `TXTKV_ASSERT(a_idle_data_silent, (item_valid && (item.cmd == CMD_DATA) && !active_r) |-> !res_valid, "result from data while idle")
  `TXTKV_ASSERT(a_no_char_clean, (res_valid && !res.has_char) |-> (res.char_byte == 8'h00 && !res.in_value), "stray character bits")

endmodule

`default_nettype wire

// ----- design/txtkv_out_reg.sv -----
// ----------------------------------------------------------------------------
// txtkv_out_reg: result register
// Holds one result item for the receiver; reloads whenever the pipe advances.
// ----------------------------------------------------------------------------
`default_nettype none

module txtkv_out_reg
  import txtkv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    advance,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         out_valid,
  output result_t      out_res
);

  `include "txt_record_key_value_parse_core_assert.svh"

  logic    valid_r;
  result_t res_r;

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Checks
  `TXTKV_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !valid_r, "result valid after reset")
  `TXTKV_ASSERT(a_hold_when_blocked, ($past(valid_r) && !$past(advance)) |-> (valid_r && $stable(res_r)), "held result changed")

endmodule

`default_nettype wire

// ----- design/txt_record_key_value_parse_core.sv -----
// ----------------------------------------------------------------------------
// txt_record_key_value_parse_core: TXT record key=value attribute splitter
//
// Input channel (in_valid/in_stall): a start item (cmd 0) carries the record
// data length; data items (cmd 1) carry one record data byte each.
// Result channel (out_valid/out_stall): zero or one result per input item,
// with the character, its key/value tag, entry end, record end and status.
// An item is taken on a clock edge with valid high and stall low.
// Throughput: one item per cycle while out_stall stays low. Each item is
// registered, its step is worked out in combinational counter and compare
// logic, and the result lands in the output register, which drives
// out_valid once the item has moved on from the input register.
// A stall on the result side holds the output register; the input register
// then holds its item and in_stall rises in the same cycle, so at most two
// items are in flight.
// Reset (rst_n low, synchronous) empties both registers and leaves the
// parser idle with no record active.
// ----------------------------------------------------------------------------
`default_nettype none

module txt_record_key_value_parse_core
  import txtkv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [15:0] in_rdata_length,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_has_char,
  output logic [7:0]       out_char_byte,
  output logic             out_in_value,
  output logic             out_entry_end,
  output logic             out_record_end,
  output logic             out_status
);

  logic    item_valid_r;
  item_t   item_r;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Pipe moves when the output register is empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.cmd          <= in_cmd;
      item_r.rdata_length <= in_rdata_length;
      item_r.data_byte    <= in_data_byte;
    end
  end

  txtkv_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid_r),
    .item       (item_r),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  txtkv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_has_char   = out_res.has_char;
  assign out_char_byte  = out_res.char_byte;
  assign out_in_value   = out_res.in_value;
  assign out_entry_end  = out_res.entry_end;
  assign out_record_end = out_res.record_end;
  assign out_status     = out_res.status;

endmodule

`default_nettype wire
